/* src/all_pairs_shortest_path_core_assert.svh */
// -----------------------------------------------------------------------------
// all_pairs_shortest_path_core_assert.svh
// Assertion macros shared by the all-pairs shortest path core.
// -----------------------------------------------------------------------------
`ifndef ALL_PAIRS_SHORTEST_PATH_CORE_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define APSP_ASSERT_ALWAYS(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define APSP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define APSP_ASSERT_ALWAYS(name, clk, rst_n, expr, msg)
`define APSP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

/* src/apsp_pkg.sv */
// -----------------------------------------------------------------------------
// apsp_pkg
// Types, constants and microcode table of the all-pairs shortest path core.
// -----------------------------------------------------------------------------
package apsp_pkg;

    localparam int unsigned VERTEX_W  = 3;
    localparam int unsigned WEIGHT_W  = 18;
    localparam int unsigned ADDR_W    = 2 * VERTEX_W;
    localparam int unsigned MAT_DEPTH = 1 << ADDR_W;
    localparam int unsigned PC_W      = 4;

    typedef logic [VERTEX_W-1:0] t_vertex;
    typedef logic [WEIGHT_W-1:0] t_weight;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [PC_W-1:0]     t_pc;

    localparam t_weight INF_RESET = 18'd99999;

    typedef enum logic [2:0] {
        C_NEVER,
        C_LOAD_DONE,
        C_J_LAST,
        C_MORE_RELAX,
        C_OUT_FREE,
        C_MORE_EMIT
    } t_cond;

    typedef enum logic [1:0] {
        E_NEXT,
        E_STAY,
        E_HOME
    } t_else;

    localparam t_pc S_LOAD  = 4'd0;
    localparam t_pc S_KINIT = 4'd1;
    localparam t_pc S_RIK   = 4'd2;
    localparam t_pc S_WIK   = 4'd3;
    localparam t_pc S_RELAX = 4'd4;
    localparam t_pc S_DRAIN = 4'd5;
    localparam t_pc S_EINIT = 4'd6;
    localparam t_pc S_EREAD = 4'd7;
    localparam t_pc S_EWAIT = 4'd8;
    localparam t_pc S_ENEXT = 4'd9;

    typedef struct packed {
        logic  in_rdy;
        logic  clr_cnt;
        logic  rd_ik;
        logic  lat_dik;
        logic  rd_relax;
        logic  adv_ik;
        logic  rd_emit;
        logic  emit;
        t_cond cond;
        t_pc   target;
        t_else els;
    } t_ctl_word;

    typedef struct packed {
        logic load_done;
        logic j_last;
        logic ik_last;
        logic out_free;
        logic emit_home;
    } t_seq_status;

    function automatic t_ctl_word ucode(input t_pc pc);
        t_ctl_word w;
        w        = '0;
        w.cond   = C_NEVER;
        w.target = S_LOAD;
        w.els    = E_NEXT;
        unique case (pc)
            S_LOAD: begin
                w.in_rdy = 1'b1;
                w.cond   = C_LOAD_DONE;
                w.target = S_KINIT;
                w.els    = E_STAY;
            end
            S_KINIT: begin
                w.clr_cnt = 1'b1;
            end
            S_RIK: begin
                w.rd_ik = 1'b1;
            end
            S_WIK: begin
                w.lat_dik  = 1'b1;
                w.rd_relax = 1'b1;
            end
            S_RELAX: begin
                w.rd_relax = 1'b1;
                w.cond     = C_J_LAST;
                w.target   = S_DRAIN;
                w.els      = E_STAY;
            end
            S_DRAIN: begin
                w.adv_ik = 1'b1;
                w.cond   = C_MORE_RELAX;
                w.target = S_RIK;
            end
            S_EINIT: begin
                w.clr_cnt = 1'b1;
            end
            S_EREAD: begin
                w.rd_emit = 1'b1;
            end
            S_EWAIT: begin
                w.rd_emit = 1'b1;
                w.emit    = 1'b1;
                w.cond    = C_OUT_FREE;
                w.target  = S_ENEXT;
                w.els     = E_STAY;
            end
            S_ENEXT: begin
                w.cond   = C_MORE_EMIT;
                w.target = S_EREAD;
                w.els    = E_HOME;
            end
            default: begin
                w.els = E_HOME;
            end
        endcase
        return w;
    endfunction

endpackage

/* src/apsp_if.sv */
// -----------------------------------------------------------------------------
// apsp_if
// Valid/ready channels of the all-pairs shortest path core.
// -----------------------------------------------------------------------------
interface apsp_in_if;
    import apsp_pkg::*;

    logic    valid;
    logic    ready;
    t_vertex src_vertex;
    t_vertex dst_vertex;
    t_weight edge_weight;
    logic    load_done;

    modport source (
        output valid, src_vertex, dst_vertex, edge_weight, load_done,
        input  ready
    );
    modport sink (
        input  valid, src_vertex, dst_vertex, edge_weight, load_done,
        output ready
    );
endinterface

interface apsp_out_if;
    import apsp_pkg::*;

    logic    valid;
    logic    ready;
    t_vertex out_src;
    t_vertex out_dst;
    t_weight distance;
    logic    unreachable;
    logic    last_result;

    modport source (
        output valid, out_src, out_dst, distance, unreachable, last_result,
        input  ready
    );
    modport sink (
        input  valid, out_src, out_dst, distance, unreachable, last_result,
        output ready
    );
endinterface

/* src/apsp_ram.sv */
// -----------------------------------------------------------------------------
// apsp_ram
// Generic RAM: one write port, two registered read ports.
// -----------------------------------------------------------------------------
module apsp_ram #(
    parameter int unsigned WIDTH = 18,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* src/apsp_seq.sv */
// -----------------------------------------------------------------------------
// apsp_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// -----------------------------------------------------------------------------
module apsp_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  apsp_pkg::t_seq_status i_status,
    output apsp_pkg::t_ctl_word  o_ctl
);
    import apsp_pkg::*;

    t_pc       r_pc;
    t_pc       n_pc;
    t_ctl_word ctl;
    logic      cond_hit;

    assign ctl = ucode(r_pc);

    always_comb begin
        unique case (ctl.cond)
            C_NEVER:      cond_hit = 1'b0;
            C_LOAD_DONE:  cond_hit = i_status.load_done;
            C_J_LAST:     cond_hit = i_status.j_last;
            C_MORE_RELAX: cond_hit = !i_status.ik_last;
            C_OUT_FREE:   cond_hit = i_status.out_free;
            C_MORE_EMIT:  cond_hit = !i_status.emit_home;
            default:      cond_hit = 1'b0;
        endcase
    end

    always_comb begin
        if (cond_hit) begin
            n_pc = ctl.target;
        end else begin
            unique case (ctl.els)
                E_NEXT:  n_pc = r_pc + t_pc'(1);
                E_STAY:  n_pc = r_pc;
                E_HOME:  n_pc = S_LOAD;
                default: n_pc = S_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl = ctl;

endmodule

/* src/all_pairs_shortest_path_core.sv */
// -----------------------------------------------------------------------------
// all_pairs_shortest_path_core
// Floyd-Warshall all-pairs shortest path over a loaded adjacency matrix.
// Load: one matrix entry per cycle.
// Compute: for each k and each i, read d[i][k], latch it, relax row i against
//   row k along j, then drain the last write and step i, then k.
// Emit: one distance at a time, each read, presented and stepped past before
//   the next, held while the sink is not ready, in row-major order.
// Reset: sequencer back to load, output empty, infinity back to 99999;
//   the matrix RAM is not cleared.
// -----------------------------------------------------------------------------
`include "all_pairs_shortest_path_core_assert.svh"

module all_pairs_shortest_path_core #(
    parameter int unsigned NUM_VERTICES = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  apsp_pkg::t_weight   i_cfg_wdata,
    apsp_in_if.sink             i_in_chan,
    apsp_out_if.source          o_out_chan
);
    import apsp_pkg::*;

    localparam t_vertex               LAST_V = VERTEX_W'(NUM_VERTICES - 1);
    localparam logic [VERTEX_W:0]     NV_EXT = (VERTEX_W + 1)'(NUM_VERTICES);

    t_ctl_word   ctl;
    t_seq_status status;

    t_weight r_inf;
    t_vertex r_i;
    t_vertex r_j;
    t_vertex r_k;
    t_weight r_dik;
    logic    r_pv;
    t_vertex r_pi;
    t_vertex r_pj;

    logic    r_ov;
    t_vertex r_osrc;
    t_vertex r_odst;
    t_weight r_odist;
    logic    r_ounr;
    logic    r_olast;

    logic    in_accept;
    logic    in_range;
    logic    load_we;
    logic    relax_we;
    logic    out_free;
    logic    emit_fire;
    t_vertex j_inc;
    t_vertex i_inc;
    t_vertex k_inc;

    t_addr   raddr_a;
    t_addr   raddr_b;
    t_addr   waddr;
    t_weight wdata;
    t_weight rd_a;
    t_weight rd_b;
    logic [WEIGHT_W:0] sum;

    apsp_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctl    (ctl)
    );

    apsp_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (MAT_DEPTH)
    ) u_mat (
        .i_clk     (i_clk),
        .i_we      (load_we || relax_we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign i_in_chan.ready = ctl.in_rdy;
    assign in_accept = i_in_chan.valid && ctl.in_rdy;
    assign in_range  = ({1'b0, i_in_chan.src_vertex} < NV_EXT)
                    && ({1'b0, i_in_chan.dst_vertex} < NV_EXT);
    assign load_we   = in_accept && in_range;

    assign sum      = {1'b0, r_dik} + {1'b0, rd_a};
    assign relax_we = r_pv && (r_dik != r_inf) && (rd_a != r_inf) && (sum < {1'b0, rd_b});

    always_comb begin
        if (relax_we) begin
            waddr = {r_pi, r_pj};
            wdata = sum[WEIGHT_W-1:0];
        end else begin
            waddr = {i_in_chan.src_vertex, i_in_chan.dst_vertex};
            wdata = i_in_chan.edge_weight;
        end
    end

    always_comb begin
        if (ctl.rd_relax) begin
            raddr_a = {r_k, r_j};
        end else if (ctl.rd_emit) begin
            raddr_a = {r_i, r_j};
        end else begin
            raddr_a = {r_i, r_k};
        end
    end
    assign raddr_b = {r_i, r_j};

    assign out_free  = !r_ov || o_out_chan.ready;
    assign emit_fire = ctl.emit && out_free;

    assign j_inc = (r_j == LAST_V) ? '0 : r_j + t_vertex'(1);
    assign i_inc = (r_i == LAST_V) ? '0 : r_i + t_vertex'(1);
    assign k_inc = (r_k == LAST_V) ? '0 : r_k + t_vertex'(1);

    assign status.load_done = in_accept && i_in_chan.load_done;
    assign status.j_last    = (r_j == LAST_V);
    assign status.ik_last   = (r_i == LAST_V) && (r_k == LAST_V);
    assign status.out_free  = out_free;
    assign status.emit_home = (r_i == '0) && (r_j == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inf <= INF_RESET;
        end else if (i_cfg_we) begin
            r_inf <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i  <= '0;
            r_j  <= '0;
            r_k  <= '0;
            r_pv <= 1'b0;
        end else begin
            r_pv <= ctl.rd_relax;
            if (ctl.clr_cnt) begin
                r_i <= '0;
                r_j <= '0;
                r_k <= '0;
            end
            if (ctl.rd_relax) begin
                r_j <= j_inc;
            end
            if (ctl.adv_ik) begin
                r_i <= i_inc;
                if (r_i == LAST_V) begin
                    r_k <= k_inc;
                end
            end
            if (emit_fire) begin
                r_j <= j_inc;
                if (r_j == LAST_V) begin
                    r_i <= i_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pi <= r_i;
        r_pj <= r_j;
        if (ctl.lat_dik) begin
            r_dik <= rd_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit_fire) begin
            r_ov <= 1'b1;
        end else if (o_out_chan.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_osrc  <= r_i;
            r_odst  <= r_j;
            r_odist <= rd_a;
            r_ounr  <= (rd_a == r_inf);
            r_olast <= (r_i == LAST_V) && (r_j == LAST_V);
        end
    end

    assign o_out_chan.valid       = r_ov;
    assign o_out_chan.out_src     = r_osrc;
    assign o_out_chan.out_dst     = r_odst;
    assign o_out_chan.distance    = r_odist;
    assign o_out_chan.unreachable = r_ounr;
    assign o_out_chan.last_result = r_olast;

    `APSP_ASSERT_ALWAYS(a_one_writer, i_clk, i_rst_n, !(load_we && relax_we), "load and relaxation write collide")
    `APSP_ASSERT_ALWAYS(a_drained_on_load, i_clk, i_rst_n, !ctl.in_rdy || !r_pv, "relaxation still in flight while loading")
    `APSP_ASSERT_NEXT(a_emit_wrap, i_clk, i_rst_n, emit_fire && (r_i == LAST_V) && (r_j == LAST_V), (r_i == '0) && (r_j == '0) && r_olast, "final distance did not wrap the emit counters")
    `APSP_ASSERT_NEXT(a_emit_shown, i_clk, i_rst_n, emit_fire, r_ov, "emitted distance not presented")

endmodule

/* tb/sv/apsp_distance_checker.sv */
// -----------------------------------------------------------------------------
// apsp_distance_checker
// Watches the configuration port and both channels of the all-pairs shortest
// path core. Keeps its own copy of the distance matrix and the infinity weight,
// solves the matrix on every entry that carries load_done, queues the N*N
// expected distances and compares each result transaction field by field.
// -----------------------------------------------------------------------------
module apsp_distance_checker #(
    parameter int unsigned NUM_VERTICES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  apsp_pkg::t_weight i_cfg_wdata,
    apsp_in_if                i_in_chan,
    apsp_out_if               i_out_chan,
    output int                o_mismatch_count,
    output int                o_distances_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import apsp_pkg::*;

    typedef struct {
        t_vertex src;
        t_vertex dst;
        t_weight path_dist;
        logic    unreach;
        logic    last;
    } t_distance_rec;

    t_weight       path_len [NUM_VERTICES][NUM_VERTICES];
    t_weight       inf_weight = INF_RESET;
    t_distance_rec expected_distances [$];
    int            mismatches = 0;

    initial begin
        o_mismatch_count    = 0;
        o_distances_pending = 0;
    end

    function automatic void relax_shortest_paths();
        t_weight           d_ik;
        t_weight           d_kj;
        logic [WEIGHT_W:0] via_k;
        for (int k = 0; k < NUM_VERTICES; k++) begin
            for (int i = 0; i < NUM_VERTICES; i++) begin
                d_ik = path_len[i][k];
                if (d_ik != inf_weight) begin
                    for (int j = 0; j < NUM_VERTICES; j++) begin
                        d_kj = path_len[k][j];
                        if (d_kj != inf_weight) begin
                            via_k = {1'b0, d_ik} + {1'b0, d_kj};
                            if (via_k < {1'b0, path_len[i][j]}) begin
                                path_len[i][j] = via_k[WEIGHT_W-1:0];
                            end
                        end
                    end
                end
            end
        end
    endfunction

    function automatic void queue_distance_set();
        t_distance_rec rec;
        for (int i = 0; i < NUM_VERTICES; i++) begin
            for (int j = 0; j < NUM_VERTICES; j++) begin
                rec.src       = t_vertex'(i);
                rec.dst       = t_vertex'(j);
                rec.path_dist = path_len[i][j];
                rec.unreach   = (path_len[i][j] == inf_weight);
                rec.last      = (i == NUM_VERTICES - 1) && (j == NUM_VERTICES - 1);
                expected_distances.push_back(rec);
            end
        end
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : track
        t_distance_rec want;
        int            src_idx;
        int            dst_idx;
        if (!i_rst_n) begin
            inf_weight = INF_RESET;
            expected_distances.delete();
        end else begin
            if (i_cfg_we) begin
                inf_weight = i_cfg_wdata;
            end
            if (i_in_chan.valid && i_in_chan.ready) begin
                src_idx = int'(i_in_chan.src_vertex);
                dst_idx = int'(i_in_chan.dst_vertex);
                if (src_idx < NUM_VERTICES && dst_idx < NUM_VERTICES) begin
                    path_len[src_idx][dst_idx] = i_in_chan.edge_weight;
                end
                if (i_in_chan.load_done) begin
                    relax_shortest_paths();
                    queue_distance_set();
                end
            end
            if (i_out_chan.valid && i_out_chan.ready) begin
                if (expected_distances.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: unexpected distance, expected none, actual %0d->%0d = %0d",
                             $time, i_out_chan.out_src, i_out_chan.out_dst,
                             i_out_chan.distance);
                end else begin
                    want = expected_distances.pop_front();
                    check_field("out_src", want.src, i_out_chan.out_src);
                    check_field("out_dst", want.dst, i_out_chan.out_dst);
                    check_field("distance", want.path_dist, i_out_chan.distance);
                    check_field("unreachable", want.unreach, i_out_chan.unreachable);
                    check_field("last_result", want.last, i_out_chan.last_result);
                end
            end
        end
        o_mismatch_count    <= mismatches;
        o_distances_pending <= expected_distances.size();
    end

endmodule

/* tb/sv/tb_top.sv */
// -----------------------------------------------------------------------------
// tb_top
// Drives the all-pairs shortest path core: a full first matrix load, directed
// entries at the weight extremes and infinity settings, then random partial
// reloads, each mostly closed by load_done. Random gaps on both channels, one
// long output hold-off and drained pauses; the checker judges every distance.
// -----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import apsp_pkg::*;

    localparam int unsigned NUM_VERTICES      = 8;
    localparam int unsigned ITEM_TARGET       = 260;
    localparam int unsigned LONG_HOLD_CYCLES  = 1500;
    localparam int unsigned HOLD_PHASE        = 4;
    localparam int unsigned CFG_SETTLE_CYCLES = 8;
    localparam int unsigned END_SETTLE_CYCLES = 20;
    localparam t_weight     WEIGHT_MAX        = '1;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    i_cfg_we;
    t_weight i_cfg_wdata;

    apsp_in_if  in_chan ();
    apsp_out_if out_chan ();

    int      mismatch_count;
    int      distances_pending;
    t_weight inf_now          = INF_RESET;
    bit      tx_idle_on       = 1'b1;
    bit      rx_idle_on       = 1'b1;
    int      hold_len_req     = 0;
    bit      long_hold_taken  = 1'b0;
    int      entries_sent     = 0;
    int      solves_sent      = 0;
    int      cfg_writes       = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    all_pairs_shortest_path_core #(
        .NUM_VERTICES(NUM_VERTICES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_chan  (in_chan),
        .o_out_chan (out_chan)
    );

    apsp_distance_checker #(
        .NUM_VERTICES(NUM_VERTICES)
    ) distance_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_chan          (in_chan),
        .i_out_chan         (out_chan),
        .o_mismatch_count   (mismatch_count),
        .o_distances_pending(distances_pending)
    );

    function automatic t_weight rand_weight(input t_weight inf);
        case ($urandom_range(0, 9))
            0, 1:       return inf;
            2, 3, 4, 5: return t_weight'($urandom_range(0, 30));
            6:          return WEIGHT_MAX;
            7:          return '0;
            default:    return t_weight'($urandom_range(0, WEIGHT_MAX));
        endcase
    endfunction

    function automatic t_weight pick_infinity();
        case ($urandom_range(0, 4))
            0:       return INF_RESET;
            1:       return '0;
            2:       return WEIGHT_MAX;
            3:       return t_weight'($urandom_range(1, 40));
            default: return t_weight'($urandom_range(0, WEIGHT_MAX));
        endcase
    endfunction

    function automatic t_weight seed_weight(input int i, input int j);
        if (i == j) return '0;
        if (j == (i + 1) % NUM_VERTICES) return t_weight'(i + 1);
        if ((i * 3 + j) % 7 == 0) return WEIGHT_MAX;
        if ((i + j) % 4 == 1) return t_weight'(50 + i * j);
        return inf_now;
    endfunction

    task automatic send_entry(input int src, input int dst, input t_weight w,
                              input logic done);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            in_chan.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_chan.valid       <= 1'b1;
        in_chan.src_vertex  <= t_vertex'(src);
        in_chan.dst_vertex  <= t_vertex'(dst);
        in_chan.edge_weight <= w;
        in_chan.load_done   <= done;
        @(posedge i_clk);
        while (!in_chan.ready) @(posedge i_clk);
        entries_sent++;
        if (done) solves_sent++;
    endtask

    task automatic wait_drained();
        in_chan.valid <= 1'b0;
        do @(posedge i_clk); while (distances_pending != 0);
    endtask

    task automatic set_infinity(input t_weight value);
        wait_drained();
        repeat (CFG_SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        inf_now = value;
        cfg_writes++;
    endtask

    initial begin : result_sink
        int stall;
        out_chan.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_len_req != 0 && !long_hold_taken) begin
                long_hold_taken = 1'b1;
                out_chan.ready <= 1'b0;
                repeat (hold_len_req) @(posedge i_clk);
            end else begin
                stall = rx_idle_on ? $urandom_range(0, 3) : 0;
                if (stall != 0) begin
                    out_chan.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_chan.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_chan.valid) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int   phase;
        int   count;
        logic with_done;
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_wdata         <= '0;
        in_chan.valid       <= 1'b0;
        in_chan.src_vertex  <= '0;
        in_chan.dst_vertex  <= '0;
        in_chan.edge_weight <= '0;
        in_chan.load_done   <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // write every entry before the first solve
        set_infinity(INF_RESET);
        for (int i = 0; i < NUM_VERTICES; i++) begin
            for (int j = 0; j < NUM_VERTICES; j++) begin
                send_entry(i, j, seed_weight(i, j),
                           (i == NUM_VERTICES - 1) && (j == NUM_VERTICES - 1));
            end
        end

        send_entry(0, 7, '0, 1'b0);
        send_entry(7, 0, WEIGHT_MAX, 1'b0);
        send_entry(3, 4, inf_now, 1'b0);
        send_entry(5, 5, t_weight'(7), 1'b1);
        send_entry(2, 2, '0, 1'b1);

        set_infinity('0);
        send_entry(1, 2, '0, 1'b0);
        send_entry(2, 3, t_weight'(5), 1'b0);
        send_entry(0, 1, t_weight'(3), 1'b1);

        set_infinity(WEIGHT_MAX);
        send_entry(0, 1, t_weight'(200000), 1'b0);
        send_entry(1, 2, t_weight'(200000), 1'b0);
        send_entry(0, 2, WEIGHT_MAX, 1'b0);
        send_entry(4, 5, t_weight'(131071), 1'b0);
        send_entry(5, 6, t_weight'(131072), 1'b0);
        send_entry(4, 6, WEIGHT_MAX, 1'b1);

        set_infinity(INF_RESET);

        phase = 0;
        while (entries_sent < ITEM_TARGET) begin
            phase++;
            if (phase != HOLD_PHASE && phase != HOLD_PHASE + 1 && $urandom_range(0, 3) == 0) begin
                set_infinity(pick_infinity());
            end
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            // keep offering entries while the output is held off
            if (phase == HOLD_PHASE) hold_len_req = LONG_HOLD_CYCLES;
            count     = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 64)
                                                    : $urandom_range(1, 8);
            with_done = (phase == HOLD_PHASE) || ($urandom_range(0, 9) != 0);
            for (int e = 0; e < count; e++) begin
                send_entry($urandom_range(0, NUM_VERTICES - 1),
                           $urandom_range(0, NUM_VERTICES - 1),
                           rand_weight(inf_now), with_done && (e == count - 1));
            end
            if (phase != HOLD_PHASE && (phase % 7 == 0 || $urandom_range(0, 4) == 0)) begin
                wait_drained();
            end
        end

        // close any open load so every entry is solved
        send_entry($urandom_range(0, NUM_VERTICES - 1), $urandom_range(0, NUM_VERTICES - 1),
                   rand_weight(inf_now), 1'b1);
        wait_drained();
        repeat (END_SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d matrix entries in %0d solves, %0d infinity settings,",
                 entries_sent, solves_sent, cfg_writes);
        $display("one %0d-cycle output hold-off with entries still offered.", LONG_HOLD_CYCLES);
        if (mismatch_count == 0 && distances_pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

/* all_pairs_shortest_path_core.f */
+incdir+src
src/apsp_pkg.sv
src/apsp_if.sv
src/apsp_ram.sv
src/apsp_seq.sv
src/all_pairs_shortest_path_core.sv
tb/sv/apsp_distance_checker.sv
tb/sv/tb_top.sv
